>>> hw/rtl/b2ss_pkg.sv
// b2ss_pkg: shared types, constants and helper functions for the
// binary to seven-segment scan block. No dependencies.
package b2ss_pkg;

	localparam int COUNT_W  = 16;
	localparam int POS_W    = 3;
	localparam int SEG_W    = 7;
	localparam int DIGIT_W  = 4;
	localparam int DIGIT_N  = 5;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_N - 1);

	localparam logic [COUNT_W-1:0] UNIT_TEN_THOUSANDS = 16'd10000;
	localparam logic [COUNT_W-1:0] UNIT_THOUSANDS     = 16'd1000;
	localparam logic [COUNT_W-1:0] UNIT_HUNDREDS      = 16'd100;
	localparam logic [COUNT_W-1:0] UNIT_TENS          = 16'd10;

	// active-low patterns, bit0 segment a through bit6 segment g
	localparam logic [SEG_W-1:0] SEG_TABLE [10] = '{
		7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
		7'h12, 7'h02, 7'h78, 7'h00, 7'h10
	};

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		digit_t               digit;
		logic [COUNT_W-1:0]   rem;
	} split_t;

	// one decimal digit: nine parallel compares against multiples of unit
	function automatic split_t dec_split(input logic [COUNT_W-1:0] v,
		input logic [COUNT_W-1:0] unit);
		split_t      res;
		logic [19:0] step;
		res.digit = '0;
		res.rem   = v;
		step      = '0;
		for (int k = 1; k < 10; k++) begin
			step = 20'(k) * 20'(unit);
			if (20'(v) >= step) begin
				res.digit = DIGIT_W'(k);
				res.rem   = v - step[COUNT_W-1:0];
			end
		end
		return res;
	endfunction

	// segment lookup, codes above nine show the nine pattern
	function automatic logic [SEG_W-1:0] seg_of(input digit_t d);
		logic [SEG_W-1:0] s;
		if (d > 4'd9) begin
			s = SEG_TABLE[9];
		end else begin
			s = SEG_TABLE[d];
		end
		return s;
	endfunction

endpackage

>>> hw/rtl/binary_to_seven_segment_scan_top.sv
// binary_to_seven_segment_scan_top: count to five-digit seven-segment scan.
// Depends on b2ss_pkg.
//
// Usage: one 16-bit count enters on the s_ channel (s_tdata[15:0]). For each
// count the m_ channel gives five items in the order units, tens, hundreds,
// thousands, ten-thousands; each names the digit position (m_tdata[2:0]) and
// its active-low segment pattern (m_tdata[9:3]). m_tlast marks the
// ten-thousands item. Leading zeros are shown, not blanked.
// Flow: a count passes stages 1, 2 and 3, then the scan register, before its
// units item shows. The five output items leave the scan register one per
// cycle while m_tready is high. Three conversion stages in front (ten-thousands,
// thousands, hundreds, with tens and units split on the way into the scan
// register) each take one count per cycle when not stalled, so the next count
// is ready to load on the edge that takes the previous count's last item.
// Reset: arst_n clears all valid bits and the scan position; nothing else.
// Stall: when m_tready is low the current item holds; the conversion stages
// keep filling until full, then s_tready drops. Nothing is lost or repeated.
module binary_to_seven_segment_scan_top
	import b2ss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] count_value
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [2:0] digit_position, [9:3] segments, zeros
	output logic                   m_tlast    // last_digit
);

	// stage 1: ten-thousands digit
	logic         valid_s1;
	digit_t       d4_s1;
	logic [13:0]  rem_s1;
	// stage 2: thousands digit
	logic         valid_s2;
	digit_t       d4_s2, d3_s2;
	logic [9:0]   rem_s2;
	// stage 3: hundreds digit
	logic         valid_s3;
	digit_t       d4_s3, d3_s3, d2_s3;
	logic [6:0]   rem_s3;
	// stage 4: scan register
	logic         valid_s4;
	digit_t       dig_s4 [DIGIT_N];
	logic [POS_W-1:0] pos_s4;

	logic   rdy_s1, rdy_s2, rdy_s3, load_s4, is_last;
	split_t sp4, sp3, sp2, sp1;

	assign is_last  = (pos_s4 == LAST_POS);
	assign load_s4  = !valid_s4 || (m_tready && is_last);
	assign rdy_s3   = !valid_s3 || load_s4;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// digit splits, one per stage
	always_comb begin
		sp4 = dec_split(s_tdata[COUNT_W-1:0], UNIT_TEN_THOUSANDS);
		sp3 = dec_split(COUNT_W'(rem_s1), UNIT_THOUSANDS);
		sp2 = dec_split(COUNT_W'(rem_s2), UNIT_HUNDREDS);
		sp1 = dec_split(COUNT_W'(rem_s3), UNIT_TENS);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= s_tvalid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (load_s4) valid_s4 <= valid_s3;
		end
	end

	// conversion payload
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			d4_s1  <= sp4.digit;
			rem_s1 <= sp4.rem[13:0];
		end
		if (rdy_s2) begin
			d4_s2  <= d4_s1;
			d3_s2  <= sp3.digit;
			rem_s2 <= sp3.rem[9:0];
		end
		if (rdy_s3) begin
			d4_s3  <= d4_s2;
			d3_s3  <= d3_s2;
			d2_s3  <= sp2.digit;
			rem_s3 <= sp2.rem[6:0];
		end
		if (load_s4) begin
			dig_s4[0] <= sp1.rem[DIGIT_W-1:0];
			dig_s4[1] <= sp1.digit;
			dig_s4[2] <= d2_s3;
			dig_s4[3] <= d3_s3;
			dig_s4[4] <= d4_s3;
		end
	end

	// scan position, steps on each delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_s4 <= '0;
		end else if (valid_s4 && m_tready) begin
			if (is_last) begin
				pos_s4 <= '0;
			end else begin
				pos_s4 <= pos_s4 + POS_W'(1);
			end
		end
	end

	// output item
	always_comb begin
		m_tvalid = valid_s4;
		m_tlast  = is_last;
		m_tdata  = {(OUT_TDATA_W - POS_W - SEG_W)'(0), seg_of(dig_s4[pos_s4]), pos_s4};
	end

endmodule

>>> hw/rtl/b2ss_checker.sv
// b2ss_checker: port-level checks for the seven-segment scan block, bound
// to binary_to_seven_segment_scan_top. Depends on b2ss_pkg.
module b2ss_checker
	import b2ss_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	// a stalled item stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output item dropped while stalled");

	// a run of digits is never broken up
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a digit run");

	// positions count up by one inside a run
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
		m_tdata[2:0] == 3'($past(m_tdata[2:0]) + 3'd1))
		else $error("digit position skipped");

	// last mark sits on the ten-thousands item, padding is zero
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[2:0] == LAST_POS)) && (m_tdata[15:10] == 6'd0))
		else $error("last mark or padding wrong");

endmodule

bind binary_to_seven_segment_scan_top b2ss_checker u_b2ss_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
